/* hdl/scalc_pkg.sv */
package scalc_pkg;

    // Widths of the channel payloads.
    localparam int KEY_W    = 8;
    localparam int RESULT_W = 32;

    // Line buffer size in characters, one slot kept for the terminator.
    localparam int BUFFER_CHARS = 20;
    localparam int CNT_W        = $clog2(BUFFER_CHARS);

    // Width of the operands and of the arithmetic.
    localparam int VALUE_W = 32;
    localparam int STEP_W  = $clog2(VALUE_W + 1);

    // Set-1 scan codes that the block reacts to.
    localparam logic [KEY_W-1:0] KEY_DIGIT1 = 8'h02;
    localparam logic [KEY_W-1:0] KEY_DIGIT9 = 8'h0A;
    localparam logic [KEY_W-1:0] KEY_DIGIT0 = 8'h0B;
    localparam logic [KEY_W-1:0] KEY_PLUS   = 8'h4E;
    localparam logic [KEY_W-1:0] KEY_MINUS  = 8'h4A;
    localparam logic [KEY_W-1:0] KEY_STAR   = 8'h37;
    localparam logic [KEY_W-1:0] KEY_SLASH  = 8'h35;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h1C;

    // Second operand that stands in when none was typed.
    localparam logic [VALUE_W-1:0] DEFAULT_SECOND = VALUE_W'(2);

    // Operator codes.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    // Parser position within the line.
    typedef enum logic [2:0] {
        PH_START1  = 3'd0,
        PH_SIGN1   = 3'd1,
        PH_DIGITS1 = 3'd2,
        PH_START2  = 3'd3,
        PH_SIGN2   = 3'd4,
        PH_DIGITS2 = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // Maps an operator key to its code, anything else to no operator.
    function automatic t_op op_of(input logic [KEY_W-1:0] sc);
        t_op op;
        unique case (sc)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_STAR:  op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

/* hdl/scalc_key_if.sv */
interface scalc_key_if import scalc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

/* hdl/scalc_res_if.sv */
interface scalc_res_if import scalc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

/* hdl/scancode_calculator_top.sv */
// Keys other than Enter are taken while idle; the parser updates on the transfer itself.
// After an Enter transfer, a load state sets up the operation, a step state runs the shared
// adder (one pass a bit with * or /, skipped with no operator or a zero divisor), and a sign
// state hands the result on. No new key is taken while a result is computed or waits for a
// full output register; a finished result waits in an output register while keys are taken
// again. Synchronous reset clears the line parser, the sequencer and the output valid flag.
module scancode_calculator_top import scalc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scalc_key_if.sink   i_key,
    scalc_res_if.source o_res
);

    localparam logic [VALUE_W-1:0] VALUE_CAP = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_CAP - VALUE_W'(1);
    localparam logic [CNT_W-1:0]   CNT_LIMIT = CNT_W'(BUFFER_CHARS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_SIGN
    } t_state;

    t_state                     r_state;

    // Line parser state.
    t_phase                     r_phase;
    logic [VALUE_W-1:0]         r_first;
    logic                       r_first_neg;
    t_op                        r_op;
    logic [VALUE_W-1:0]         r_second;
    logic                       r_second_neg;
    logic                       r_second_seen;
    logic [CNT_W-1:0]           r_count;

    // Datapath of the shared unit.
    t_op                        r_calc_op;
    logic [VALUE_W:0]           r_acc;
    logic [VALUE_W-1:0]         r_x;
    logic [VALUE_W-1:0]         r_y;
    logic                       r_na;
    logic                       r_nb;
    logic                       r_neg;
    logic [STEP_W-1:0]          r_cnt;

    // Output register.
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out_data;

    // Next values of the parser.
    t_phase                     n_phase;
    logic [VALUE_W-1:0]         n_first;
    logic                       n_first_neg;
    t_op                        n_op;
    logic [VALUE_W-1:0]         n_second;
    logic                       n_second_neg;
    logic                       n_second_seen;

    logic                       key_xfer;
    logic                       is_enter;
    logic                       is_digit;
    logic [3:0]                 digit;
    t_op                        key_op;
    logic [VALUE_W-1:0]         acc_mag;
    logic [VALUE_W+3:0]         acc_prod;
    logic [VALUE_W-1:0]         acc_next;

    logic [VALUE_W-1:0]         ma;
    logic [VALUE_W-1:0]         mb;
    logic                       na;
    logic                       nb;

    logic [VALUE_W:0]           u_x;
    logic [VALUE_W:0]           u_y;
    logic                       u_sub;
    logic [VALUE_W+1:0]         u_sum;
    logic                       out_free;
    logic                       res_load;

    assign key_xfer           = i_key.valid && i_key.ready;
    assign i_key.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_data;
    assign out_free           = !r_out_valid || o_res.ready;
    assign res_load           = (r_state == S_SIGN) && out_free;

    // Key decode.
    always_comb begin
        is_enter = (i_key.scan_code == KEY_ENTER);
        key_op   = op_of(i_key.scan_code);
        if (i_key.scan_code >= KEY_DIGIT1 && i_key.scan_code <= KEY_DIGIT9) begin
            is_digit = 1'b1;
            digit    = 4'(i_key.scan_code - KEY_W'(1));
        end else if (i_key.scan_code == KEY_DIGIT0) begin
            is_digit = 1'b1;
            digit    = 4'd0;
        end else begin
            is_digit = 1'b0;
            digit    = 4'd0;
        end
    end

    // Decimal accumulate with saturation at the negative limit's magnitude.
    always_comb begin
        acc_mag  = (r_phase == PH_DIGITS2) ? r_second : r_first;
        acc_prod = {1'b0, acc_mag, 3'b000} + {3'b000, acc_mag, 1'b0}
                 + (VALUE_W+4)'(digit);
        acc_next = (acc_prod > (VALUE_W+4)'(VALUE_CAP)) ? VALUE_CAP
                                                        : acc_prod[VALUE_W-1:0];
    end

    // Parser step for one accepted character.
    always_comb begin
        n_phase       = r_phase;
        n_first       = r_first;
        n_first_neg   = r_first_neg;
        n_op          = r_op;
        n_second      = r_second;
        n_second_neg  = r_second_neg;
        n_second_seen = r_second_seen;
        unique case (r_phase)
            PH_START1: begin
                if (is_digit) begin
                    n_first = VALUE_W'(digit);
                    n_phase = PH_DIGITS1;
                end else if (key_op == OP_ADD || key_op == OP_SUB) begin
                    n_first_neg = (key_op == OP_SUB);
                    n_phase     = PH_SIGN1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIGN1: begin
                if (is_digit) begin
                    n_first = VALUE_W'(digit);
                    n_phase = PH_DIGITS1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DIGITS1: begin
                if (is_digit) begin
                    n_first = acc_next;
                end else begin
                    n_op    = key_op;
                    n_phase = PH_START2;
                end
            end
            PH_START2: begin
                if (is_digit) begin
                    n_second      = VALUE_W'(digit);
                    n_second_seen = 1'b1;
                    n_phase       = PH_DIGITS2;
                end else if (key_op == OP_ADD || key_op == OP_SUB) begin
                    n_second_neg = (key_op == OP_SUB);
                    n_phase      = PH_SIGN2;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIGN2: begin
                if (is_digit) begin
                    n_second      = VALUE_W'(digit);
                    n_second_seen = 1'b1;
                    n_phase       = PH_DIGITS2;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DIGITS2: begin
                if (is_digit) begin
                    n_second = acc_next;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Operand magnitudes and signs; a positive value is clamped one below the cap.
    always_comb begin
        na = r_first_neg && (r_first != '0);
        if (r_first_neg) begin
            ma = r_first;
        end else begin
            ma = (r_first == VALUE_CAP) ? VALUE_MAX : r_first;
        end
        if (!r_second_seen) begin
            mb = DEFAULT_SECOND;
            nb = 1'b0;
        end else begin
            nb = r_second_neg && (r_second != '0);
            if (r_second_neg) begin
                mb = r_second;
            end else begin
                mb = (r_second == VALUE_CAP) ? VALUE_MAX : r_second;
            end
        end
    end

    // Operand select for the shared add/subtract unit.
    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_STEP: begin
                unique case (r_calc_op)
                    OP_MUL: begin
                        u_x = r_acc;
                        u_y = r_y[0] ? {1'b0, r_x} : '0;
                    end
                    OP_DIV: begin
                        u_x   = {r_acc[VALUE_W-1:0], r_y[VALUE_W-1]};
                        u_y   = {1'b0, r_x};
                        u_sub = 1'b1;
                    end
                    default: begin
                        u_x   = r_acc;
                        u_y   = {1'b0, r_x};
                        u_sub = (r_cnt == STEP_W'(2)) ? r_na
                                                      : (r_nb ^ (r_calc_op == OP_SUB));
                    end
                endcase
            end
            S_SIGN: begin
                u_y   = {1'b0, (r_calc_op == OP_DIV) ? r_y : r_acc[VALUE_W-1:0]};
                u_sub = r_neg;
            end
            default: begin
            end
        endcase
        u_sum = {1'b0, u_x} + {1'b0, (u_sub ? ~u_y : u_y)} + (VALUE_W+2)'(u_sub);
    end

    // Sequencer, parser registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_START1;
            r_first       <= '0;
            r_first_neg   <= 1'b0;
            r_op          <= OP_NONE;
            r_second      <= '0;
            r_second_neg  <= 1'b0;
            r_second_seen <= 1'b0;
            r_count       <= '0;
            r_calc_op     <= OP_NONE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // The output valid flag is set by a new result and cleared by its transfer.
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (key_xfer) begin
                        if (is_enter) begin
                            r_state <= S_LOAD;
                        end else if ((is_digit || key_op != OP_NONE)
                                     && r_count < CNT_LIMIT) begin
                            r_count       <= r_count + CNT_W'(1);
                            r_phase       <= n_phase;
                            r_first       <= n_first;
                            r_first_neg   <= n_first_neg;
                            r_op          <= n_op;
                            r_second      <= n_second;
                            r_second_neg  <= n_second_neg;
                            r_second_seen <= n_second_seen;
                        end
                    end
                end
                S_LOAD: begin
                    // Set up the operation, then start a fresh line.
                    r_acc <= '0;
                    r_na  <= na;
                    r_nb  <= nb;
                    unique case (r_op)
                        OP_ADD, OP_SUB: begin
                            r_calc_op <= r_op;
                            r_x       <= ma;
                            r_y       <= mb;
                            r_neg     <= 1'b0;
                            r_cnt     <= STEP_W'(2);
                            r_state   <= S_STEP;
                        end
                        OP_MUL: begin
                            r_calc_op <= OP_MUL;
                            r_x       <= ma;
                            r_y       <= mb;
                            r_neg     <= na ^ nb;
                            r_cnt     <= STEP_W'(VALUE_W);
                            r_state   <= S_STEP;
                        end
                        OP_DIV: begin
                            if (mb == '0) begin
                                r_calc_op <= OP_NONE;
                                r_neg     <= 1'b0;
                                r_state   <= S_SIGN;
                            end else begin
                                r_calc_op <= OP_DIV;
                                r_x       <= mb;
                                r_y       <= ma;
                                r_neg     <= na ^ nb;
                                r_cnt     <= STEP_W'(VALUE_W);
                                r_state   <= S_STEP;
                            end
                        end
                        default: begin
                            r_calc_op <= OP_NONE;
                            r_neg     <= 1'b0;
                            r_state   <= S_SIGN;
                        end
                    endcase
                    r_phase       <= PH_START1;
                    r_first       <= '0;
                    r_first_neg   <= 1'b0;
                    r_op          <= OP_NONE;
                    r_second      <= '0;
                    r_second_neg  <= 1'b0;
                    r_second_seen <= 1'b0;
                    r_count       <= '0;
                end
                S_STEP: begin
                    unique case (r_calc_op)
                        OP_MUL: begin
                            r_acc <= {1'b0, u_sum[VALUE_W-1:0]};
                            r_x   <= r_x << 1;
                            r_y   <= r_y >> 1;
                        end
                        OP_DIV: begin
                            // Restoring division: keep the difference when no borrow.
                            r_acc <= u_sum[VALUE_W+1] ? u_sum[VALUE_W:0] : u_x;
                            r_y   <= {r_y[VALUE_W-2:0], u_sum[VALUE_W+1]};
                        end
                        default: begin
                            r_acc <= {1'b0, u_sum[VALUE_W-1:0]};
                            r_x   <= r_y;
                        end
                    endcase
                    r_cnt <= r_cnt - STEP_W'(1);
                    if (r_cnt == STEP_W'(1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    // Apply the sign and hand the result to the output register.
                    if (out_free) begin
                        r_out_data <= RESULT_W'($signed(u_sum[VALUE_W-1:0]));
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/tb_scancode_calculator_top.sv */
// Tracks the line parser and computes the value that each Enter must produce.
class line_calculator;
    scalc_pkg::t_phase phase;
    scalc_pkg::t_op    op;
    bit [63:0]         mag_a;
    bit [63:0]         mag_b;
    bit                neg_a;
    bit                neg_b;
    bit                seen_b;
    int unsigned       chars;
    bit [63:0]         value_mask;
    bit [63:0]         sign_cap;

    logic signed [scalc_pkg::RESULT_W-1:0] pending_values[$];
    int failures;

    function new();
        sign_cap   = 64'd1 << (scalc_pkg::VALUE_W - 1);
        value_mask = (sign_cap << 1) - 64'd1;
        failures   = 0;
        clear_line();
    endfunction

    function void clear_line();
        phase  = scalc_pkg::PH_START1;
        op     = scalc_pkg::OP_NONE;
        mag_a  = '0;
        mag_b  = '0;
        neg_a  = 1'b0;
        neg_b  = 1'b0;
        seen_b = 1'b0;
        chars  = 0;
    endfunction

    // Adds one decimal digit, saturating at the magnitude of the most negative value.
    function bit [63:0] accumulate(bit [63:0] mag, bit [63:0] digit);
        if (mag > (sign_cap - digit) / 64'd10) begin
            return sign_cap;
        end
        return mag * 64'd10 + digit;
    endfunction

    // Applies the sign to a magnitude; positive values clamp to the largest value.
    function bit [63:0] signed_value(bit neg, bit [63:0] mag);
        if (neg) begin
            return (64'd0 - mag) & value_mask;
        end
        if (mag > sign_cap - 64'd1) begin
            return (sign_cap - 64'd1) & value_mask;
        end
        return mag & value_mask;
    endfunction

    // Notes one accepted key transfer; Enter queues the value of the line.
    function void note_key(logic [scalc_pkg::KEY_W-1:0] sc);
        bit                is_digit;
        bit [63:0]         digit;
        scalc_pkg::t_op    key_op;
        bit [63:0]         a;
        bit [63:0]         b;
        bit [63:0]         ma;
        bit [63:0]         mb;
        bit [63:0]         q;
        bit [63:0]         r;
        bit                na;
        bit                nb;

        is_digit = 1'b0;
        digit    = '0;
        if (sc >= scalc_pkg::KEY_DIGIT1 && sc <= scalc_pkg::KEY_DIGIT9) begin
            is_digit = 1'b1;
            digit    = 64'(sc - scalc_pkg::KEY_DIGIT1) + 64'd1;
        end else if (sc == scalc_pkg::KEY_DIGIT0) begin
            is_digit = 1'b1;
        end
        case (sc)
            scalc_pkg::KEY_PLUS:  key_op = scalc_pkg::OP_ADD;
            scalc_pkg::KEY_MINUS: key_op = scalc_pkg::OP_SUB;
            scalc_pkg::KEY_STAR:  key_op = scalc_pkg::OP_MUL;
            scalc_pkg::KEY_SLASH: key_op = scalc_pkg::OP_DIV;
            default:              key_op = scalc_pkg::OP_NONE;
        endcase

        // Enter evaluates whatever the line holds and starts a new line.
        if (sc == scalc_pkg::KEY_ENTER) begin
            r = '0;
            if (op != scalc_pkg::OP_NONE) begin
                a = signed_value(neg_a, mag_a);
                b = seen_b ? signed_value(neg_b, mag_b) : 64'(scalc_pkg::DEFAULT_SECOND);
                case (op)
                    scalc_pkg::OP_ADD: r = (a + b) & value_mask;
                    scalc_pkg::OP_SUB: r = (a - b) & value_mask;
                    scalc_pkg::OP_MUL: r = (a * b) & value_mask;
                    default: begin
                        if (b != 64'd0) begin
                            na = (a & sign_cap) != 64'd0;
                            nb = (b & sign_cap) != 64'd0;
                            ma = na ? ((64'd0 - a) & value_mask) : a;
                            mb = nb ? ((64'd0 - b) & value_mask) : b;
                            q  = ma / mb;
                            r  = (na != nb) ? ((64'd0 - q) & value_mask) : (q & value_mask);
                        end
                    end
                endcase
            end
            if ((r & sign_cap) != 64'd0) begin
                r = r | ~value_mask;
            end
            pending_values.push_back(r[scalc_pkg::RESULT_W-1:0]);
            clear_line();
            return;
        end

        // Other keys are ignored, and a full line drops further characters.
        if (!is_digit && key_op == scalc_pkg::OP_NONE) begin
            return;
        end
        if (chars >= scalc_pkg::BUFFER_CHARS - 1) begin
            return;
        end
        chars++;

        case (phase)
            scalc_pkg::PH_START1: begin
                if (is_digit) begin
                    mag_a = digit;
                    phase = scalc_pkg::PH_DIGITS1;
                end else if (key_op == scalc_pkg::OP_ADD || key_op == scalc_pkg::OP_SUB) begin
                    neg_a = (key_op == scalc_pkg::OP_SUB);
                    phase = scalc_pkg::PH_SIGN1;
                end else begin
                    phase = scalc_pkg::PH_DONE;
                end
            end
            scalc_pkg::PH_SIGN1: begin
                if (is_digit) begin
                    mag_a = digit;
                    phase = scalc_pkg::PH_DIGITS1;
                end else begin
                    phase = scalc_pkg::PH_DONE;
                end
            end
            scalc_pkg::PH_DIGITS1: begin
                if (is_digit) begin
                    mag_a = accumulate(mag_a, digit);
                end else begin
                    op    = key_op;
                    phase = scalc_pkg::PH_START2;
                end
            end
            scalc_pkg::PH_START2: begin
                if (is_digit) begin
                    mag_b  = digit;
                    seen_b = 1'b1;
                    phase  = scalc_pkg::PH_DIGITS2;
                end else if (key_op == scalc_pkg::OP_ADD || key_op == scalc_pkg::OP_SUB) begin
                    neg_b = (key_op == scalc_pkg::OP_SUB);
                    phase = scalc_pkg::PH_SIGN2;
                end else begin
                    phase = scalc_pkg::PH_DONE;
                end
            end
            scalc_pkg::PH_SIGN2: begin
                if (is_digit) begin
                    mag_b  = digit;
                    seen_b = 1'b1;
                    phase  = scalc_pkg::PH_DIGITS2;
                end else begin
                    phase = scalc_pkg::PH_DONE;
                end
            end
            scalc_pkg::PH_DIGITS2: begin
                if (is_digit) begin
                    mag_b = accumulate(mag_b, digit);
                end else begin
                    phase = scalc_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Compares one result transfer with the oldest value still owed.
    function void check_result(logic signed [scalc_pkg::RESULT_W-1:0] got);
        logic signed [scalc_pkg::RESULT_W-1:0] want;

        if (pending_values.size() == 0) begin
            if (failures < 10) begin
                $display("unexpected result transfer: result_value=%0d", got);
            end
            failures++;
            return;
        end
        want = pending_values.pop_front();
        if (got !== want) begin
            if (failures < 10) begin
                $display("result_value mismatch: expected %0d (%h), got %0d (%h)",
                         want, want, got, got);
            end
            failures++;
        end
    endfunction
endclass

module tb_scancode_calculator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import scalc_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 10;
    localparam int          RANDOM_ITEMS   = 1600;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          DRAIN_CYCLES   = 2 * (VALUE_W + 3) + 10;
    localparam longint      TIMEOUT_CYCLES = 600000;

    logic i_clk;
    logic i_rst_n;

    scalc_key_if key_if ();
    scalc_res_if res_if ();

    scancode_calculator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_res   (res_if)
    );

    line_calculator   calc;
    logic [KEY_W-1:0] key_stream[$];
    int               counted_keys;
    bit               noise_on;
    int               burst_left;
    bit               hold_req;
    bit               hold_done;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Both channels are watched on the edge at which a transfer completes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                calc.check_result(res_if.result_value);
            end
            if (key_if.valid && key_if.ready) begin
                calc.note_key(key_if.scan_code);
            end
        end
    end

    // Digits, operators and Enter are the keys that the parser acts on.
    function automatic bit key_counts(logic [KEY_W-1:0] code);
        return (code >= KEY_DIGIT1 && code <= KEY_DIGIT0) || code == KEY_PLUS ||
               code == KEY_MINUS || code == KEY_STAR || code == KEY_SLASH ||
               code == KEY_ENTER;
    endfunction

    // Queues one key, now and then preceded by a random raw byte.
    task automatic push_key(logic [KEY_W-1:0] code);
        logic [KEY_W-1:0] raw;

        if (noise_on && $urandom_range(24, 0) == 0) begin
            raw = KEY_W'($urandom_range(255, 0));
            key_stream.push_back(raw);
            if (key_counts(raw)) begin
                counted_keys++;
            end
        end
        key_stream.push_back(code);
        if (key_counts(code)) begin
            counted_keys++;
        end
    endtask

    // Queues the keys for a line of text; '=' stands for Enter.
    task automatic add_text(string s);
        logic [KEY_W-1:0] code;

        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "0":     code = KEY_DIGIT0;
                "+":     code = KEY_PLUS;
                "-":     code = KEY_MINUS;
                "*":     code = KEY_STAR;
                "/":     code = KEY_SLASH;
                "=":     code = KEY_ENTER;
                default: code = KEY_DIGIT1 + KEY_W'(s[i] - "1");
            endcase
            push_key(code);
        end
    endtask

    // Picks an operator key, or a digit or operator key at random.
    function automatic logic [KEY_W-1:0] random_key(bit op_only);
        int pick;

        if (op_only || $urandom_range(1, 0) == 0) begin
            pick = $urandom_range(3, 0);
            case (pick)
                0:       return KEY_PLUS;
                1:       return KEY_MINUS;
                2:       return KEY_STAR;
                default: return KEY_SLASH;
            endcase
        end
        pick = $urandom_range(9, 0);
        return (pick == 9) ? KEY_DIGIT0 : KEY_DIGIT1 + KEY_W'(pick);
    endfunction

    // Queues an operand: optional sign, then a short, long or boundary number.
    task automatic add_operand();
        int pick;

        pick = $urandom_range(99, 0);
        if (pick < 15) begin
            push_key(KEY_MINUS);
        end else if (pick < 22) begin
            push_key(KEY_PLUS);
        end
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            case ($urandom_range(4, 0))
                0:       add_text("2147483647");
                1:       add_text("2147483648");
                2:       add_text("2147483649");
                3:       add_text("4294967296");
                default: add_text("0");
            endcase
        end else begin
            repeat ((pick < 18) ? $urandom_range(14, 9) : $urandom_range(4, 1)) begin
                pick = $urandom_range(9, 0);
                push_key((pick == 9) ? KEY_DIGIT0 : KEY_DIGIT1 + KEY_W'(pick));
            end
        end
    endtask

    // Offers one key and waits for its transfer; bursts end in a random gap.
    task automatic send_key(logic [KEY_W-1:0] code, bit last_key);
        key_if.valid     <= 1'b1;
        key_if.scan_code <= code;
        do begin
            @(posedge i_clk);
        end while (!key_if.ready);
        if (last_key) begin
            key_if.valid <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left   = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                       : $urandom_range(20, 0);
            key_if.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    endtask

    // Result side: stretches of random stall patterns and one long hold-off.
    initial begin : receiver
        int       stretch;
        int       mode;
        bit [7:0] pattern;

        res_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stretch = $urandom_range(100, 10);
                mode    = $urandom_range(3, 0);
                pattern = 8'($urandom_range(255, 0)) | 8'h01;
                for (int k = 0; k < stretch; k++) begin
                    case (mode)
                        0:       res_if.ready <= 1'b1;
                        1:       res_if.ready <= 1'($urandom_range(1, 0));
                        2:       res_if.ready <= ($urandom_range(3, 0) == 0);
                        default: res_if.ready <= pattern[k % 8];
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Key side: directed lines, then random lines, then drain and verdict.
    initial begin : stimulus
        int random_start;
        int pick;

        i_rst_n          <= 1'b0;
        key_if.valid     <= 1'b0;
        key_if.scan_code <= '0;
        calc       = new();
        noise_on   = 1'b0;
        burst_left = 0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ignored codes at both ends of the byte range, then one line per corner.
        key_stream.push_back(8'h00);
        key_stream.push_back(8'hFF);
        add_text("9/0=");
        add_text("*=");
        add_text("5=");
        add_text("-3-=");
        add_text("4*-7+1=");
        add_text("6+2=");

        // Mostly well-formed expressions, the rest arbitrary key runs.
        random_start = key_stream.size();
        counted_keys = 0;
        noise_on     = 1'b1;
        while (counted_keys < RANDOM_ITEMS) begin
            if ($urandom_range(9, 0) < 7) begin
                add_operand();
                push_key(random_key(1'b1));
                if ($urandom_range(9, 0) != 0) begin
                    add_operand();
                end
                if ($urandom_range(99, 0) < 15) begin
                    repeat ($urandom_range(5, 1)) push_key(random_key(1'b0));
                end
            end else begin
                pick = $urandom_range(22, 0);
                repeat (pick) push_key(random_key(1'b0));
            end
            push_key(KEY_ENTER);
        end

        for (int idx = 0; idx < key_stream.size(); idx++) begin
            if (idx == random_start) begin
                hold_req = 1'b1;
            end
            send_key(key_stream[idx], idx == key_stream.size() - 1);
        end

        while (calc.pending_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (calc.failures == 0 && calc.pending_values.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
hdl/scalc_pkg.sv
hdl/scalc_key_if.sv
hdl/scalc_res_if.sv
hdl/scancode_calculator_top.sv
tb/sv/tb_scancode_calculator_top.sv
